// ===== hdl/assert_macros.svh =====
// assertion helpers used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HCP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcp assertion failed");

// antecedent implies consequent in the next cycle
`define HCP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcp assertion failed");

`endif

// ===== hdl/hcp_pkg.sv =====
// ---------------------------------------------------------------------------
// hcp_pkg
// types and constants of the hodoscope cluster position block
// ---------------------------------------------------------------------------
`default_nettype none

package hcp_pkg;

	localparam logic [1:0] CMD_MAP     = 2'd0;
	localparam logic [1:0] CMD_PATTERN = 2'd1;
	localparam logic [1:0] CMD_EOE     = 2'd2;

	localparam logic [2:0] REG_BID0  = 3'd0;
	localparam logic [2:0] REG_BID1  = 3'd1;
	localparam logic [2:0] REG_OFFX0 = 3'd2;
	localparam logic [2:0] REG_OFFY0 = 3'd3;
	localparam logic [2:0] REG_OFFX1 = 3'd4;
	localparam logic [2:0] REG_OFFY1 = 3'd5;

	localparam logic [31:0] BID0_RESET = 32'h0802_0002;
	localparam logic [31:0] BID1_RESET = 32'h0802_0001;

	// -99 mm in eighth mm, and 999 mm in quarter mm
	localparam logic signed [11:0] NO_PAIR_POS = -12'sd792;
	localparam logic [11:0]        START_DIFF  = 12'd3996;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUILD,
		ST_SCAN,
		ST_MATCH,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       en;
		logic       half;
		logic [4:0] bit_pos;
		logic [6:0] fiber;
	} map_wr_t;

endpackage

`default_nettype wire

// ===== hdl/hcp_if.sv =====
// ---------------------------------------------------------------------------
// hcp_in_if / hcp_out_if
// request channels of the hodoscope cluster position block
// ---------------------------------------------------------------------------
`default_nettype none

interface hcp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] board_id;
	logic [1:0]  channel;
	logic [31:0] pattern_word;
	logic        map_half;
	logic [4:0]  map_bit;
	logic [6:0]  map_fiber;

	modport source (output valid, command, board_id, channel, pattern_word,
		map_half, map_bit, map_fiber, input ready);
	modport sink (input valid, command, board_id, channel, pattern_word,
		map_half, map_bit, map_fiber, output ready);
endinterface

interface hcp_out_if;
	logic               valid;
	logic               ready;
	logic               axis;
	logic [6:0]         first_size_plane0;
	logic [6:0]         first_size_plane1;
	logic signed [10:0] single_pos_plane0;
	logic signed [10:0] single_pos_plane1;
	logic signed [6:0]  best_index_plane0;
	logic signed [6:0]  best_index_plane1;
	logic signed [11:0] best_pos;
	logic               last;

	modport source (output valid, axis, first_size_plane0, first_size_plane1,
		single_pos_plane0, single_pos_plane1, best_index_plane0, best_index_plane1,
		best_pos, last, input ready);
	modport sink (input valid, axis, first_size_plane0, first_size_plane1,
		single_pos_plane0, single_pos_plane1, best_index_plane0, best_index_plane1,
		best_pos, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/hcp_fiber_map.sv =====
// ---------------------------------------------------------------------------
// hcp_fiber_map
// bit to fiber permutation memory, filtered writes, registered read
// ---------------------------------------------------------------------------
`default_nettype none

module hcp_fiber_map
	import hcp_pkg::*;
#(
	parameter int FIBERS = 64
) (
	input  wire logic       clk,
	input  wire map_wr_t    wr,
	input  wire logic [5:0] raddr,
	output logic      [5:0] rdata
);

	localparam int HALF = FIBERS / 2;

	logic [5:0] mem [64];
	logic       wr_ok;

	// fiber is one based; entries outside the fiber range are dropped
	assign wr_ok = wr.en && (wr.fiber != 7'd0) && (wr.fiber <= 7'(FIBERS))
		&& ({1'b0, wr.bit_pos} < 6'(HALF));

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[{wr.half, wr.bit_pos}] <= 6'(wr.fiber - 7'd1);
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/hodoscope_cluster_position_core.sv =====
// ---------------------------------------------------------------------------
// hodoscope_cluster_position_core
// fiber hodoscope cluster finder and plane-to-plane matcher
// ---------------------------------------------------------------------------
// usage:
//   src carries requests: map entry loads (command 0), pattern words
//   (command 1) routed by board id and channel, and end of event (command 2)
//   dst returns two results per end of event, x axis first, last set on y
//   cfg_we/cfg_index/cfg_data writes board ids and offsets; the user does
//   so only while idle, as the block does not enforce it
// operation:
//   map and pattern requests are taken directly while idle
//   end of event runs one shared sequencer per axis: for each plane a map
//   walk and a run scan, then, if both planes hold clusters, a pair search
//   through one subtract/compare unit, then the axis result
//   src.ready is low from end of event until the second result is taken
// reset:
//   arst_n clears the sequencer, the pattern store and the registers to
//   their reset values; the fiber map is not cleared and must be loaded
// stall:
//   a result holds on dst until taken; the sequencer waits on it
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hodoscope_cluster_position_core
	import hcp_pkg::*;
#(
	parameter int FIBERS       = 64,
	parameter int MAX_CLUSTERS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	hcp_in_if.sink           src,
	hcp_out_if.source        dst,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int HALF  = FIBERS / 2;
	localparam int KC_W  = $clog2(FIBERS + 1);
	localparam int LIT_W = $clog2(FIBERS);
	localparam int SZ_W  = $clog2(FIBERS + 1);
	localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
	localparam int IDX_W = $clog2(MAX_CLUSTERS);

	state_t state_q, state_d;

	// configuration
	logic [31:0]        bid_q [2];
	logic signed [9:0]  off_q [4];

	// pattern store, index {plane, axis, half}
	logic [31:0] pat_q [8];

	// sequencer position
	logic            axis_q;
	logic            plane_q;
	logic [KC_W-1:0] k_q;
	logic [KC_W-1:0] s_q;

	// lit fibers of the plane under work
	logic [FIBERS-1:0] lit_q;
	logic              bld_vld_s1;
	logic              bit_s1;

	// run tracking
	logic [LIT_W-1:0] start_q;
	logic [SZ_W-1:0]  run_q;

	// per plane cluster summary
	logic [CNT_W-1:0]   cnt_q  [2];
	logic [SZ_W-1:0]    fsz_q  [2];
	logic signed [10:0] fpos_q [2];

	// cluster center memories, one per plane
	logic signed [10:0] pos0_mem [MAX_CLUSTERS];
	logic signed [10:0] pos1_mem [MAX_CLUSTERS];
	logic signed [10:0] rd0_q, rd1_q;

	// pair search
	logic [IDX_W-1:0]   i0_q, i1_q;
	logic [IDX_W-1:0]   i0_s1, i1_s1;
	logic               m_vld_s1;
	logic [11:0]        diff_q;
	logic signed [11:0] best_q;
	logic signed [6:0]  b0_q, b1_q;

	// map port
	map_wr_t    map_wr;
	logic [5:0] map_raddr;
	logic [5:0] map_rdata;

	logic        acc;
	logic        hit0, hit1;
	logic        pat_axis;
	logic        k_half;
	logic [4:0]  k_bit;
	logic        scan_on;
	logic        scan_close;
	logic        scan_store;
	logic        scan_end;
	logic        match_last;
	logic        both_found;
	logic signed [11:0] pos_full;
	logic signed [10:0] pos_new;
	logic signed [11:0] pd;
	logic [11:0]        pd_abs;

	assign acc = src.valid && src.ready;

	// board routing, plane zero wins on equal ids
	assign hit0     = (src.board_id == bid_q[0]);
	assign hit1     = (src.board_id == bid_q[1]);
	assign pat_axis = ~src.channel[1];

	assign map_wr.en      = acc && (src.command == CMD_MAP);
	assign map_wr.half    = src.map_half;
	assign map_wr.bit_pos = src.map_bit;
	assign map_wr.fiber   = src.map_fiber;

	// map walk: entry k maps to half k/HALF, bit k%HALF
	assign k_half    = (k_q >= KC_W'(HALF));
	assign k_bit     = k_half ? 5'(k_q - KC_W'(HALF)) : 5'(k_q);
	assign map_raddr = {k_half, k_bit};

	hcp_fiber_map #(
		.FIBERS (FIBERS)
	) u_map (
		.clk   (clk),
		.wr    (map_wr),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// run scan, one position past the last fiber closes a trailing run
	assign scan_end   = (s_q == KC_W'(FIBERS));
	assign scan_on    = !scan_end && lit_q[s_q[LIT_W-1:0]];
	assign scan_close = !scan_on && (run_q != '0);
	assign scan_store = (state_q == ST_SCAN) && scan_close
		&& (cnt_q[plane_q] < CNT_W'(MAX_CLUSTERS));

	// center = 2*start - FIBERS + size + offset, quarter mm
	assign pos_full = $signed({5'd0, start_q, 1'b0}) - 12'sd0 - 12'(FIBERS)
		+ $signed(12'(run_q)) + 12'(off_q[{plane_q, axis_q}]);
	assign pos_new  = 11'(pos_full);

	// a trailing run of plane one is stored on the same edge as the scan ends
	assign both_found = (cnt_q[0] != '0) && ((cnt_q[1] != '0) || scan_store);
	assign match_last = (i0_q == IDX_W'(cnt_q[0] - 1'b1))
		&& (i1_q == IDX_W'(cnt_q[1] - 1'b1));

	// shared subtract/compare unit
	assign pd     = 12'(rd0_q) - 12'(rd1_q);
	assign pd_abs = pd[11] ? 12'(-pd) : pd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && (src.command == CMD_EOE)) begin
					state_d = ST_BUILD;
				end
			end
			ST_BUILD: begin
				if (k_q == KC_W'(FIBERS)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					if (!plane_q) begin
						state_d = ST_BUILD;
					end else if (both_found) begin
						state_d = ST_MATCH;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_MATCH: begin
				if (match_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (dst.ready) begin
					state_d = axis_q ? ST_IDLE : ST_BUILD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_q[0]   <= BID0_RESET;
			bid_q[1]   <= BID1_RESET;
			for (int i = 0; i < 4; i++) off_q[i] <= '0;
			for (int i = 0; i < 8; i++) pat_q[i] <= '0;
			for (int i = 0; i < 2; i++) begin
				cnt_q[i]  <= '0;
				fsz_q[i]  <= '0;
				fpos_q[i] <= '0;
			end
			axis_q     <= 1'b0;
			plane_q    <= 1'b0;
			k_q        <= '0;
			s_q        <= '0;
			lit_q      <= '0;
			bld_vld_s1 <= 1'b0;
			bit_s1     <= 1'b0;
			start_q    <= '0;
			run_q      <= '0;
			i0_q       <= '0;
			i1_q       <= '0;
			i0_s1      <= '0;
			i1_s1      <= '0;
			m_vld_s1   <= 1'b0;
			diff_q     <= START_DIFF;
			best_q     <= NO_PAIR_POS;
			b0_q       <= -7'sd1;
			b1_q       <= -7'sd1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BID0:  bid_q[0] <= cfg_data;
					REG_BID1:  bid_q[1] <= cfg_data;
					REG_OFFX0: off_q[0] <= cfg_data[9:0];
					REG_OFFY0: off_q[1] <= cfg_data[9:0];
					REG_OFFX1: off_q[2] <= cfg_data[9:0];
					REG_OFFY1: off_q[3] <= cfg_data[9:0];
					default: ;
				endcase
			end

			bld_vld_s1 <= (state_q == ST_BUILD) && (k_q < KC_W'(FIBERS));
			bit_s1     <= pat_q[{plane_q, axis_q, k_half}][k_bit];
			if (bld_vld_s1 && bit_s1 && (7'(map_rdata) < 7'(FIBERS))) begin
				lit_q[map_rdata[LIT_W-1:0]] <= 1'b1;
			end

			m_vld_s1 <= (state_q == ST_MATCH);
			i0_s1    <= i0_q;
			i1_s1    <= i1_q;
			// strict less-than keeps the first closest pair
			if (m_vld_s1 && (pd_abs < diff_q)) begin
				diff_q <= pd_abs;
				best_q <= 12'(rd0_q) + 12'(rd1_q);
				b0_q   <= $signed(7'(i0_s1));
				b1_q   <= $signed(7'(i1_s1));
			end

			case (state_q)
				ST_IDLE: begin
					if (acc && (src.command == CMD_PATTERN) && (hit0 || hit1)) begin
						pat_q[{!hit0, pat_axis, src.channel[0]}] <= src.pattern_word;
					end
					if (acc && (src.command == CMD_EOE)) begin
						axis_q   <= 1'b0;
						plane_q  <= 1'b0;
						k_q      <= '0;
						lit_q    <= '0;
						cnt_q[0] <= '0;
						fsz_q[0] <= '0;
					end
				end
				ST_BUILD: begin
					if (k_q == KC_W'(FIBERS)) begin
						s_q   <= '0;
						run_q <= '0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_SCAN: begin
					s_q <= s_q + 1'b1;
					if (scan_on) begin
						if (run_q == '0) begin
							start_q <= s_q[LIT_W-1:0];
						end
						run_q <= run_q + 1'b1;
					end else if (scan_close) begin
						run_q <= '0;
						if (scan_store) begin
							if (cnt_q[plane_q] == '0) begin
								fsz_q[plane_q]  <= run_q;
								fpos_q[plane_q] <= pos_new;
							end
							cnt_q[plane_q] <= cnt_q[plane_q] + 1'b1;
						end
					end
					if (scan_end) begin
						if (!plane_q) begin
							plane_q  <= 1'b1;
							k_q      <= '0;
							lit_q    <= '0;
							cnt_q[1] <= '0;
							fsz_q[1] <= '0;
						end
						i0_q   <= '0;
						i1_q   <= '0;
						diff_q <= START_DIFF;
						best_q <= NO_PAIR_POS;
						b0_q   <= -7'sd1;
						b1_q   <= -7'sd1;
					end
				end
				ST_MATCH: begin
					if (i1_q == IDX_W'(cnt_q[1] - 1'b1)) begin
						i1_q <= '0;
						i0_q <= i0_q + 1'b1;
					end else begin
						i1_q <= i1_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (dst.ready) begin
						if (!axis_q) begin
							axis_q   <= 1'b1;
							plane_q  <= 1'b0;
							k_q      <= '0;
							lit_q    <= '0;
							cnt_q[0] <= '0;
							fsz_q[0] <= '0;
						end else begin
							// event done, the store starts empty for the next one
							for (int i = 0; i < 8; i++) pat_q[i] <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// cluster centers, written during the scan, read during the pair search
	always_ff @(posedge clk) begin
		if (scan_store) begin
			if (!plane_q) begin
				pos0_mem[cnt_q[0][IDX_W-1:0]] <= pos_new;
			end else begin
				pos1_mem[cnt_q[1][IDX_W-1:0]] <= pos_new;
			end
		end
		rd0_q <= pos0_mem[i0_q];
		rd1_q <= pos1_mem[i1_q];
	end

	assign src.ready = (state_q == ST_IDLE);

	assign dst.valid             = (state_q == ST_OUT);
	assign dst.axis              = axis_q;
	assign dst.first_size_plane0 = 7'(fsz_q[0]);
	assign dst.first_size_plane1 = 7'(fsz_q[1]);
	assign dst.single_pos_plane0 = (cnt_q[0] == CNT_W'(1)) ? fpos_q[0] : 11'sd0;
	assign dst.single_pos_plane1 = (cnt_q[1] == CNT_W'(1)) ? fpos_q[1] : 11'sd0;
	assign dst.best_index_plane0 = b0_q;
	assign dst.best_index_plane1 = b1_q;
	assign dst.best_pos          = best_q;
	assign dst.last              = axis_q;

	`HCP_ASSERT_IMP(a_no_accept_while_result, dst.valid, !src.ready)
	`HCP_ASSERT_IMP(a_count_bound, 1'b1,
		(cnt_q[0] <= CNT_W'(MAX_CLUSTERS)) && (cnt_q[1] <= CNT_W'(MAX_CLUSTERS)))
	`HCP_ASSERT_IMP(a_match_in_range, state_q == ST_MATCH,
		(CNT_W'(i0_q) < cnt_q[0]) && (CNT_W'(i1_q) < cnt_q[1]))
	`HCP_ASSERT_NXT(a_drain_to_out, state_q == ST_DRAIN, state_q == ST_OUT)

endmodule

`default_nettype wire

// ===== tb/hcp_checker.sv =====
// ---------------------------------------------------------------------------
// hcp_checker
// tracks requests and register writes, predicts per-axis results, compares
// ---------------------------------------------------------------------------
`default_nettype none

module hcp_checker
	import hcp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	hcp_in_if                src,
	hcp_out_if               dst,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic               axis;
		logic [6:0]         fs0;
		logic [6:0]         fs1;
		logic signed [10:0] sp0;
		logic signed [10:0] sp1;
		logic signed [6:0]  bi0;
		logic signed [6:0]  bi1;
		logic signed [11:0] bp;
		logic               last;
	} axis_result_t;

	logic [31:0]        bid [2];
	logic signed [9:0]  offs [2][2];
	logic [5:0]         fmap [64];
	logic [31:0]        hits [8];
	axis_result_t       axis_results_q [$];

	// find runs of lit fibers and match planes, one result per axis
	task automatic locate_clusters();
		int cnt [4];
		int first_sz [4];
		int pos [4][32];
		bit lit [65];
		int run, start, slot, diff, d, b0, b1, best;
		axis_result_t r;
		for (int a = 0; a < 2; a++) begin
			for (int p = 0; p < 2; p++) begin
				slot = p * 2 + a;
				foreach (lit[i]) lit[i] = 0;
				for (int h = 0; h < 2; h++)
					for (int b = 0; b < 32; b++)
						if (hits[(p * 2 + a) * 2 + h][b]) lit[fmap[h * 32 + b]] = 1;
				cnt[slot] = 0;
				first_sz[slot] = 0;
				run = 0;
				start = 0;
				for (int f = 0; f <= 64; f++) begin
					if (f < 64 && lit[f]) begin
						if (run == 0) start = f;
						run++;
					end else if (run != 0) begin
						if (cnt[slot] < 32) begin
							if (cnt[slot] == 0) first_sz[slot] = run;
							pos[slot][cnt[slot]] = 2 * start - 64 + run + int'(offs[p][a]);
							cnt[slot]++;
						end
						run = 0;
					end
				end
			end
		end
		for (int a = 0; a < 2; a++) begin
			diff = 3996;
			best = -792;
			b0 = -1;
			b1 = -1;
			for (int i = 0; i < cnt[a]; i++)
				for (int j = 0; j < cnt[2 + a]; j++) begin
					d = pos[a][i] - pos[2 + a][j];
					if (d < 0) d = -d;
					if (d < diff) begin
						diff = d;
						b0 = i;
						b1 = j;
						best = pos[a][i] + pos[2 + a][j];
					end
				end
			r.axis = a[0];
			r.fs0  = 7'(first_sz[a]);
			r.fs1  = 7'(first_sz[2 + a]);
			r.sp0  = (cnt[a] == 1) ? 11'(pos[a][0]) : '0;
			r.sp1  = (cnt[2 + a] == 1) ? 11'(pos[2 + a][0]) : '0;
			r.bi0  = 7'(b0);
			r.bi1  = 7'(b1);
			r.bp   = 12'(best);
			r.last = (a == 1);
			axis_results_q.push_back(r);
		end
		foreach (hits[i]) hits[i] = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid[0] = BID0_RESET;
			bid[1] = BID1_RESET;
			foreach (offs[i, j]) offs[i][j] = '0;
			foreach (fmap[i]) fmap[i] = '0;
			foreach (hits[i]) hits[i] = '0;
			axis_results_q.delete();
			errors = 0;
		end else begin
			axis_result_t got, want;
			if (cfg_we) begin
				case (cfg_index)
					REG_BID0:  bid[0] = cfg_data;
					REG_BID1:  bid[1] = cfg_data;
					REG_OFFX0: offs[0][0] = cfg_data[9:0];
					REG_OFFY0: offs[0][1] = cfg_data[9:0];
					REG_OFFX1: offs[1][0] = cfg_data[9:0];
					REG_OFFY1: offs[1][1] = cfg_data[9:0];
					default: ;
				endcase
			end
			if (dst.valid && dst.ready) begin
				got = {dst.axis, dst.first_size_plane0, dst.first_size_plane1,
					dst.single_pos_plane0, dst.single_pos_plane1,
					dst.best_index_plane0, dst.best_index_plane1, dst.best_pos, dst.last};
				if (axis_results_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors++;
				end else begin
					want = axis_results_q.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch expected %h actual %h", $time, want, got);
						errors++;
					end
				end
			end
			if (src.valid && src.ready) begin
				case (src.command)
					CMD_MAP:
						if (src.map_fiber >= 1 && src.map_fiber <= 64)
							fmap[{src.map_half, src.map_bit}] = 6'(src.map_fiber - 1);
					CMD_PATTERN: begin
						if (src.board_id == bid[0])
							hits[{1'b0, ~src.channel[1], src.channel[0]}] = src.pattern_word;
						else if (src.board_id == bid[1])
							hits[{1'b1, ~src.channel[1], src.channel[0]}] = src.pattern_word;
					end
					CMD_EOE: locate_clusters();
					default: ;
				endcase
			end
		end
		pending = axis_results_q.size();
	end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// random event streams through the hodoscope cluster position block
// ---------------------------------------------------------------------------
// loads a fiber map, then runs directed and random events across several
// register settings; a side checker predicts and compares every result
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
	import hcp_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 3000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors;
	int          pending;
	int          idle_cycles;
	int          item_count;
	bit          idle_en;
	bit          hold_req;
	logic [31:0] cur_bid [2];

	hcp_in_if  src ();
	hcp_out_if dst ();

	hodoscope_cluster_position_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src      (src),
		.dst      (dst),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	hcp_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.src      (src),
		.dst      (dst),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		dst.ready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				dst.ready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end
			dst.ready <= !(idle_en && $urandom_range(0, 99) < 9);
		end
	end

	// watchdog: cycles with no request moving either way
	always @(posedge clk) begin
		if ((src.valid && src.ready) || (dst.valid && dst.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// one request; valid stays high into the next one unless a gap follows
	task automatic put(input logic [1:0] cmd, input logic [31:0] bid_v,
		input logic [1:0] ch, input logic [31:0] word,
		input logic half, input logic [4:0] bitp, input logic [6:0] fib);
		while (idle_en && $urandom_range(0, 99) < 9) begin
			src.valid <= 0;
			@(posedge clk);
		end
		src.valid        <= 1;
		src.command      <= cmd;
		src.board_id     <= bid_v;
		src.channel      <= ch;
		src.pattern_word <= word;
		src.map_half     <= half;
		src.map_bit      <= bitp;
		src.map_fiber    <= fib;
		do @(posedge clk); while (!src.ready);
		item_count++;
	endtask

	// write enable stays high across back-to-back writes, the caller lowers it
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == REG_BID0) cur_bid[0] = val;
		if (idx == REG_BID1) cur_bid[1] = val;
	endtask

	// registers change only with the block drained
	task automatic settle();
		src.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] hit_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom & $urandom & $urandom;
			3: return ~($urandom & $urandom & $urandom);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_board();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return cur_bid[0];
		if (r < 90) return cur_bid[1];
		return $urandom;
	endfunction

	// well-formed event with random content, some noise mixed in
	task automatic random_event();
		int n;
		n = $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 99))
				0, 1:
					put(2'd3, $urandom, 2'($urandom), $urandom, 1'($urandom),
						5'($urandom), 7'($urandom));
				2, 3, 4:
					put(CMD_MAP, $urandom, 2'($urandom), $urandom, 1'($urandom),
						5'($urandom), ($urandom_range(0, 3) == 0) ? 7'($urandom)
						: 7'($urandom_range(1, 64)));
				default:
					put(CMD_PATTERN, pick_board(), 2'($urandom), hit_word(),
						1'($urandom), 5'($urandom), 7'($urandom));
			endcase
		end
		put(CMD_EOE, $urandom, 2'($urandom), $urandom, 1'($urandom),
			5'($urandom), 7'($urandom));
	endtask

	initial begin
		arst_n       = 0;
		cfg_we       = 0;
		cfg_index    = '0;
		cfg_data     = '0;
		src.valid    = 0;
		src.command  = CMD_MAP;
		src.board_id = '0;
		src.channel  = '0;
		src.pattern_word = '0;
		src.map_half  = 0;
		src.map_bit   = '0;
		src.map_fiber = '0;
		idle_cycles  = 0;
		item_count   = 0;
		idle_en      = 1;
		hold_req     = 0;
		cur_bid[0]   = BID0_RESET;
		cur_bid[1]   = BID1_RESET;
		repeat (4) @(posedge clk);
		arst_n = 1;
		@(posedge clk);

		// bad map entries first: fiber zero and above the last fiber
		put(CMD_MAP, '0, '0, '0, 1'b0, 5'd3, 7'd0);
		put(CMD_MAP, '0, '0, '0, 1'b1, 5'd31, 7'd65);
		put(CMD_MAP, '0, '0, '0, 1'b1, 5'd0, 7'd127);
		// identity map so every bit has an entry before any hit
		for (int k = 0; k < 64; k++)
			put(CMD_MAP, '0, '0, '0, k[5], k[4:0], 7'(k + 1));

		// empty event: no clusters anywhere
		put(CMD_EOE, '0, '0, '0, 0, '0, '0);
		// whole plane lit, 64-fiber cluster
		for (int c = 0; c < 4; c++) put(CMD_PATTERN, cur_bid[0], 2'(c), '1, 0, '0, '0);
		put(CMD_PATTERN, cur_bid[1], 2'd2, 32'h8000_0000, 0, '0, '0);
		put(CMD_PATTERN, cur_bid[1], 2'd3, 32'h8000_0000, 0, '0, '0);
		put(CMD_EOE, '0, '0, '0, 0, '0, '0);
		// maximum cluster count, cluster at last fiber, unknown board, bad command
		for (int c = 0; c < 4; c++) put(CMD_PATTERN, cur_bid[1], 2'(c), 32'h5555_5555, 0, '0, '0);
		put(CMD_PATTERN, cur_bid[0], 2'd1, 32'h8000_0000, 0, '0, '0);
		put(CMD_PATTERN, 32'hFFFF_FFFF, 2'd0, '1, 0, '0, '0);
		put(2'd3, '1, '1, '1, 1, '1, '1);
		put(CMD_EOE, '1, '1, '1, 1, '1, '1);

		for (int ph = 0; ph < 5; ph++) begin
			settle();
			case (ph)
				0: begin
					write_reg(REG_BID0, $urandom);
					write_reg(REG_BID1, $urandom);
					write_reg(REG_OFFX0, 32'd511);
					write_reg(REG_OFFY0, 32'h3FF & -512);
					write_reg(REG_OFFX1, 32'h3FF & -512);
					write_reg(REG_OFFY1, 32'd511);
				end
				1: begin
					// both ids equal: plane zero takes the words
					write_reg(REG_BID0, 32'hFFFF_FFFF);
					write_reg(REG_BID1, 32'hFFFF_FFFF);
					write_reg(REG_OFFX0, 32'h3FF & -512);
					write_reg(REG_OFFY0, 32'd511);
					write_reg(REG_OFFX1, 32'd511);
					write_reg(REG_OFFY1, 32'h3FF & -512);
				end
				2: begin
					write_reg(REG_BID0, '0);
					write_reg(REG_BID1, 32'hFFFF_FFFF);
					for (int r = REG_OFFX0; r <= REG_OFFY1; r++)
						write_reg(3'(r), $urandom);
				end
				default: begin
					write_reg(REG_BID0, BID0_RESET);
					write_reg(REG_BID1, BID1_RESET);
					for (int r = REG_OFFX0; r <= REG_OFFY1; r++)
						write_reg(3'(r), (ph == 3) ? '0 : $urandom);
				end
			endcase
			cfg_we <= 0;
			idle_en = (ph != 2);
			if (ph == 1) hold_req = 1;
			while (item_count < 150 + ph * 200) random_event();
		end

		src.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
